@@ rtl/piobc_pkg.sv @@
// ----------------------------------------------------------------------------
// piobc_pkg: shared types and constants of the oriented box counter
// Word codes, chain token, load broadcast and the multiply sequence tables.
// ----------------------------------------------------------------------------
package piobc_pkg;

   localparam int NUM_BOXES_DEF   = 16;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int BOX_WORDS       = 15;
   localparam int MAC_STEPS       = 9;
   localparam int UNIT_Q16        = 65536;
   localparam logic [15:0] MARGIN_RESET = 16'd655;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_TEST  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic CSR_NUM_BOXES = 1'b0;
   localparam logic CSR_MARGIN    = 1'b1;

   localparam logic [3:0] WS_HALF  = 4'd3;
   localparam logic [3:0] WS_AXIS  = 4'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } tok_type;

   typedef struct packed {
      logic        en;
      logic [3:0]  slot;
      logic [3:0]  word;
      logic [31:0] value;
   } load_type;

   function automatic logic [1:0] mac_row(input logic [3:0] idx);
      case (idx)
         4'd0, 4'd1, 4'd2: mac_row = 2'd0;
         4'd3, 4'd4, 4'd5: mac_row = 2'd1;
         default:          mac_row = 2'd2;
      endcase
   endfunction

   function automatic logic [1:0] mac_col(input logic [3:0] idx);
      case (idx)
         4'd0, 4'd3, 4'd6: mac_col = 2'd0;
         4'd1, 4'd4, 4'd7: mac_col = 2'd1;
         default:          mac_col = 2'd2;
      endcase
   endfunction

endpackage

@@ rtl/points_in_oriented_boxes_count.sv @@
// ----------------------------------------------------------------------------
// points_in_oriented_boxes_count: oriented box containment counter
// Loads boxes into a chain of cells and counts points that fall in any box.
// ----------------------------------------------------------------------------
// Load words reach the cells through a load register; clear words reset the
// count. A test word walks the chain: each box up to the first hit is tested
// by its cell, each box skipped (after a hit or beyond num_boxes_used) only
// passes the token on. One test word at a time; no word is taken while it runs.
// Reset: synchronous; clears the count, sets num_boxes_used 0, margin 655.
// Box words are undefined until loaded.
module points_in_oriented_boxes_count #(
   parameter int NUM_BOXES   = piobc_pkg::NUM_BOXES_DEF,
   parameter int COORD_WIDTH = piobc_pkg::COORD_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // box_slot[3:0], word_select[7:4], load_value[39:8], point_x[71:40],
   // point_y[103:72], point_z[135:104]
   input  logic [135:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // inside_any[0], inside_count[32:1], zero[39:33]
   output logic [39:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [15:0]  csr_data
);

   localparam int CW = COORD_WIDTH;

   piobc_pkg::state_type state_ff, state_in;
   logic signed [CW-1:0] point_ff [3];
   logic [4:0]           used_ff;
   logic [15:0]          margin_ff;
   logic [31:0]          count_ff;
   logic                 hit_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_any_ff;
   logic [31:0]          rsp_count_ff;
   piobc_pkg::load_type  load_ff;
   piobc_pkg::tok_type   tok [NUM_BOXES+1];
   piobc_pkg::tok_type   launch_ff;

   logic accept;
   logic is_test;
   logic rsp_free;
   logic [31:0] count_inc;

   assign accept     = req_tvalid && req_tready;
   assign is_test    = req_tuser == piobc_pkg::OP_TEST;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign count_inc  = (hit_ff && count_ff != 32'hFFFF_FFFF) ? count_ff + 32'd1 : count_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_any_ff};
   assign tok[0]     = launch_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         piobc_pkg::ST_IDLE: if (accept && is_test) state_in = piobc_pkg::ST_WALK;
         piobc_pkg::ST_WALK: if (tok[NUM_BOXES].valid) state_in = piobc_pkg::ST_HOLD;
         piobc_pkg::ST_HOLD: if (rsp_free) state_in = piobc_pkg::ST_IDLE;
         default: state_in = piobc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         piobc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            csr_ready  = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
            csr_ready  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && is_test) begin
         point_ff[0] <= CW'($signed(req_tdata[71:40]));
         point_ff[1] <= CW'($signed(req_tdata[103:72]));
         point_ff[2] <= CW'($signed(req_tdata[135:104]));
      end
      if (tok[NUM_BOXES].valid) hit_ff <= tok[NUM_BOXES].hit;
      if (state_ff == piobc_pkg::ST_HOLD && rsp_free) begin
         rsp_any_ff   <= hit_ff;
         rsp_count_ff <= count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= piobc_pkg::ST_IDLE;
         used_ff      <= '0;
         margin_ff    <= piobc_pkg::MARGIN_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         load_ff      <= '0;
         launch_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         load_ff.en    <= accept && (req_tuser == piobc_pkg::OP_LOAD);
         load_ff.slot  <= req_tdata[3:0];
         load_ff.word  <= req_tdata[7:4];
         load_ff.value <= req_tdata[39:8];
         launch_ff     <= '{valid: accept && is_test, hit: 1'b0};
         if (csr_valid && csr_ready) begin
            case (csr_index)
               piobc_pkg::CSR_NUM_BOXES: used_ff   <= csr_data[4:0];
               piobc_pkg::CSR_MARGIN:    margin_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == piobc_pkg::ST_HOLD && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= count_inc;
         end else begin
            if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
            if (accept && req_tuser == piobc_pkg::OP_CLEAR) count_ff <= '0;
         end
      end
   end

   for (genvar j = 0; j < NUM_BOXES; j++) begin : g_cell
      piobc_cell #(
         .COORD_WIDTH(COORD_WIDTH),
         .INDEX      (j)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .load          (load_ff),
         .num_boxes_used(used_ff),
         .margin_q16    (margin_ff),
         .point         (point_ff),
         .tok_in        (tok[j]),
         .tok_out       (tok[j+1])
      );
   end

endmodule

@@ rtl/piobc_cell.sv @@
// ----------------------------------------------------------------------------
// piobc_cell: one box of the chain
// Holds one box; unless the token has a hit or the box is unused, tests the
// point on one multiplier shared by the axis products, then passes the token on.
// ----------------------------------------------------------------------------
module piobc_cell #(
   parameter int COORD_WIDTH = piobc_pkg::COORD_WIDTH_DEF,
   parameter int INDEX       = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  piobc_pkg::load_type           load,
   input  logic [4:0]                    num_boxes_used,
   input  logic [15:0]                   margin_q16,
   input  logic signed [COORD_WIDTH-1:0] point [3],
   input  piobc_pkg::tok_type            tok_in,
   output piobc_pkg::tok_type            tok_out
);

   localparam int CW = COORD_WIDTH;
   localparam int DW = CW + 1;
   localparam int PW = DW + CW;
   localparam int AW = PW + 2;
   localparam int BW = CW + 17;

   logic signed [CW-1:0] centre_ff [3];
   logic signed [CW-1:0] half_ff [3];
   logic signed [CW-1:0] axis_ff [9];

   logic signed [DW-1:0] d_ff [3];
   logic signed [PW-1:0] prod_ff;
   logic [1:0]           prod_col_ff;
   logic [1:0]           prod_row_ff;
   logic                 prod_v_ff;
   logic signed [AW-1:0] acc_ff;
   logic [BW-1:0]        bound_ff;
   logic                 rowdone_ff;
   logic                 fail_ff;
   logic                 busy_ff;
   logic [3:0]           cnt_ff;
   piobc_pkg::tok_type   tok_ff;

   logic                 slot_hit;
   logic                 active;
   logic [3:0]           idx;
   logic signed [PW-1:0] prod_in;
   logic [CW-1:0]        half_mag;
   logic signed [AW-1:0] bound_s;
   logic                 chk;

   assign slot_hit = load.en && (32'(load.slot) == INDEX);
   assign active   = 32'(num_boxes_used) > INDEX;
   assign idx      = cnt_ff - 4'd1;
   assign prod_in  = d_ff[piobc_pkg::mac_col(idx)] * axis_ff[idx];
   assign half_mag = half_ff[prod_row_ff][CW-1] ? CW'(-half_ff[prod_row_ff])
                                               : CW'(half_ff[prod_row_ff]);
   assign bound_s  = $signed(AW'(bound_ff));
   assign chk      = rowdone_ff && ((acc_ff > bound_s) || (-acc_ff > bound_s));
   assign tok_out  = tok_ff;

   always_ff @(posedge clock) begin
      if (slot_hit) begin
         case (load.word) inside
            [4'd0:4'd2]:  centre_ff[load.word[1:0]] <= CW'($signed(load.value));
            [4'd3:4'd5]:  half_ff[2'(load.word - piobc_pkg::WS_HALF)] <=
                             CW'($signed(load.value));
            [4'd6:4'd14]: axis_ff[load.word - piobc_pkg::WS_AXIS] <=
                             CW'($signed(load.value));
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (tok_in.valid && !busy_ff) begin
         for (int k = 0; k < 3; k++) begin
            d_ff[k] <= DW'(point[k]) - DW'(centre_ff[k]);
         end
      end
      prod_ff     <= prod_in;
      prod_col_ff <= piobc_pkg::mac_col(idx);
      prod_row_ff <= piobc_pkg::mac_row(idx);
      if (prod_v_ff) begin
         acc_ff <= (prod_col_ff == 2'd0) ? AW'(prod_ff) : acc_ff + AW'(prod_ff);
         bound_ff <= BW'(half_mag) * BW'(17'(piobc_pkg::UNIT_Q16) + 17'(margin_q16));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         cnt_ff     <= '0;
         prod_v_ff  <= 1'b0;
         rowdone_ff <= 1'b0;
         fail_ff    <= 1'b0;
         tok_ff     <= '0;
      end else begin
         prod_v_ff  <= busy_ff && (cnt_ff >= 4'd1) && (cnt_ff <= 4'(piobc_pkg::MAC_STEPS));
         rowdone_ff <= prod_v_ff && (prod_col_ff == 2'd2);
         tok_ff     <= '0;
         if (busy_ff) begin
            fail_ff <= fail_ff | chk;
            cnt_ff  <= cnt_ff + 4'd1;
            if (cnt_ff == 4'(piobc_pkg::MAC_STEPS + 2)) begin
               busy_ff      <= 1'b0;
               tok_ff.valid <= 1'b1;
               tok_ff.hit   <= !(fail_ff | chk);
            end
         end else if (tok_in.valid) begin
            if (tok_in.hit || !active) begin
               tok_ff <= tok_in;
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= 4'd1;
               fail_ff <= 1'b0;
            end
         end
      end
   end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: regression for the oriented box containment counter
// Loads box tables, sweeps the box count and margin registers, and streams
// load, test and clear words under random back-pressure. A scoreboard class
// predicts each test result with exact wide integer math and checks the
// response words in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam logic [1:0] OP_NOP     = 2'd3;
   localparam logic [3:0] WS_IGNORE  = 4'd15;
   localparam int         NBOX       = 16;
   localparam int         DRAIN_WAIT = 260;
   localparam int         PHASE_WORDS = 13;

   class box_count_board;
      logic [31:0] words[NBOX*piobc_pkg::BOX_WORDS];
      logic [31:0] hits;
      logic [4:0]  nboxes;
      logic [15:0] margin;
      logic        want_any[$];
      logic [31:0] want_count[$];
      int          errs;

      function new();
         hits   = 0;
         nboxes = 0;
         margin = piobc_pkg::MARGIN_RESET;
         errs   = 0;
      endfunction

      function void write_reg(logic idx, logic [15:0] v);
         if (idx == piobc_pkg::CSR_NUM_BOXES) nboxes = v[4:0];
         else margin = v;
      endfunction

      function bit box_holds(int b, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
         logic signed [80:0] dv[3];
         logic signed [80:0] ax, acc, rm, bnd, scale;
         logic [31:0] pt[3];
         int base;
         pt[0] = px; pt[1] = py; pt[2] = pz;
         base = b * piobc_pkg::BOX_WORDS;
         scale = 81'(margin) + 81'd65536;
         for (int k = 0; k < 3; k++)
            dv[k] = $signed(pt[k]) - $signed(words[base+k]);
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) begin
               ax  = $signed(words[base+int'(piobc_pkg::WS_AXIS)+3*i+k]);
               acc = acc + dv[k] * ax;
            end
            if (acc < 0) acc = -acc;
            rm = $signed(words[base+int'(piobc_pkg::WS_HALF)+i]);
            if (rm < 0) rm = -rm;
            bnd = rm * scale;
            if (acc > bnd) return 0;
         end
         return 1;
      endfunction

      function void note_word(logic [1:0] op, logic [135:0] d);
         int used;
         bit hit;
         hit = 0;
         if (op == piobc_pkg::OP_LOAD) begin
            if (d[7:4] != WS_IGNORE)
               words[int'(d[3:0])*piobc_pkg::BOX_WORDS + int'(d[7:4])] = d[39:8];
         end else if (op == piobc_pkg::OP_CLEAR) begin
            hits = 0;
         end else if (op == piobc_pkg::OP_TEST) begin
            used = (nboxes > NBOX) ? NBOX : int'(nboxes);
            for (int b = 0; b < used && !hit; b++)
               hit = box_holds(b, d[71:40], d[103:72], d[135:104]);
            if (hit && hits != 32'hFFFF_FFFF) hits++;
            want_any.push_back(hit);
            want_count.push_back(hits);
         end
      endfunction

      function void check_result(logic [39:0] d);
         logic        a;
         logic [31:0] c;
         if (want_any.size() == 0) begin
            errs++;
            if (errs <= 10) $display("unexpected response word %h", d);
            return;
         end
         a = want_any.pop_front();
         c = want_count.pop_front();
         if (d[0] !== a || d[32:1] !== c || d[39:33] !== 7'd0) begin
            errs++;
            if (errs <= 10)
               $display("mismatch: expected any=%0d count=%0d, got any=%0d count=%0d pad=%h",
                        a, c, d[0], d[32:1], d[39:33]);
         end
      endfunction

      function int pending();
         return want_any.size();
      endfunction
   endclass

   logic         clock;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic [1:0]   req_tuser = OP_NOP;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = piobc_pkg::CSR_NUM_BOXES;
   logic [15:0]  csr_data = '0;

   box_count_board board = new();
   bit quiet = 0;
   int hold_cycles = 0;

   // geometry of boxes built from signed unit axes, used to aim points
   bit          tidy[NBOX];
   int          cen[NBOX][3];
   int          half[NBOX][3];
   int          perm[NBOX][3];
   int          sgn[NBOX][3];

   points_in_oriented_boxes_count u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_word(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 17);
      end
   end

   task automatic send(logic [1:0] op, logic [3:0] slot, logic [3:0] ws, logic [31:0] v,
                       logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      if (!quiet && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {pz, py, px, v, ws, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, v);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_tidy_box(int b, bit flat, bit negate);
      int p[3];
      int t, j;
      logic [31:0] v;
      p = '{0, 1, 2};
      for (int i = 2; i > 0; i--) begin
         j = $urandom_range(i);
         t = p[i]; p[i] = p[j]; p[j] = t;
      end
      for (int i = 0; i < 3; i++) begin
         perm[b][i] = p[i];
         sgn[b][i]  = $urandom_range(1) ? 1 : -1;
         cen[b][i]  = int'($urandom_range(1 << 25)) - (1 << 24);
         half[b][i] = $urandom_range(1 << 20);
      end
      if (flat) half[b][$urandom_range(2)] = 0;
      for (int ws = 0; ws < piobc_pkg::BOX_WORDS; ws++) begin
         if (ws < 3) v = cen[b][ws];
         else if (ws < 6) v = negate ? -half[b][ws-3] : half[b][ws-3];
         else v = (perm[b][(ws-6)/3] == (ws-6)%3) ? sgn[b][(ws-6)/3] * 65536 : 0;
         send(piobc_pkg::OP_LOAD, 4'(b), 4'(ws), v, $urandom, $urandom, $urandom);
      end
      tidy[b] = 1;
   endtask

   task automatic load_wild_box(int b);
      for (int ws = 0; ws < piobc_pkg::BOX_WORDS; ws++)
         send(piobc_pkg::OP_LOAD, 4'(b), 4'(ws), $urandom, $urandom, $urandom, $urandom);
      tidy[b] = 0;
   endtask

   task automatic test_aimed(int b, bit exact_zero);
      int w[3];
      int tl;
      for (int k = 0; k < 3; k++) w[k] = cen[b][k];
      for (int i = 0; i < 3; i++) begin
         tl = exact_zero ? 0 : int'($urandom_range(2 * half[b][i] * 21 / 20))
                                 - half[b][i] * 21 / 20;
         w[perm[b][i]] += sgn[b][i] * tl;
      end
      send(piobc_pkg::OP_TEST, 4'($urandom), 4'($urandom), $urandom, w[0], w[1], w[2]);
   endtask

   task automatic random_word();
      int r, b;
      r = $urandom_range(99);
      b = $urandom_range(NBOX - 1);
      if (r < 65 && tidy[b]) test_aimed(b, half[b][0] == 0 || half[b][1] == 0 ||
                                           half[b][2] == 0 ? 1'($urandom_range(1)) : 1'b0);
      else if (r < 80) send(piobc_pkg::OP_TEST, 4'($urandom), 4'($urandom), $urandom,
                            $urandom, $urandom, $urandom);
      else if (r < 86) send(piobc_pkg::OP_LOAD, 4'(b),
                            4'($urandom_range(piobc_pkg::BOX_WORDS - 1)), $urandom,
                            $urandom, $urandom, $urandom);
      else if (r < 89) send(piobc_pkg::OP_CLEAR, 4'($urandom), 4'($urandom), $urandom,
                            $urandom, $urandom, $urandom);
      else if (r < 91) send(OP_NOP, 4'($urandom), 4'($urandom), $urandom,
                            $urandom, $urandom, $urandom);
      else if (r < 93) send(piobc_pkg::OP_LOAD, 4'(b), WS_IGNORE, $urandom,
                            $urandom, $urandom, $urandom);
      else if (r < 97) load_tidy_box(b, $urandom_range(3) == 0, 1'($urandom_range(1)));
      else load_wild_box(b);
   endtask

   initial begin
      logic [4:0]  nb_set[7];
      logic [15:0] mg_set[7];
      nb_set = '{5'd16, 5'd0, 5'd16, 5'd31, 5'd5, 5'd1, 5'd16};
      mg_set = '{16'd655, 16'd0, 16'd65535, 16'd0, 16'd1000, 16'd655, 16'd0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int b = 0; b < NBOX; b++) load_tidy_box(b, b == 3, b == 5);
      send(piobc_pkg::OP_TEST, 4'd0, 4'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
      send(OP_NOP, 4'hF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(piobc_pkg::OP_LOAD, 4'd2, WS_IGNORE, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
      drain();
      write_csr(piobc_pkg::CSR_NUM_BOXES, 16'd16);
      test_aimed(0, 0);
      test_aimed(3, 1);
      test_aimed(5, 0);
      test_aimed(15, 0);
      send(piobc_pkg::OP_TEST, 4'd0, 4'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000,
           32'h7FFF_FFFF);
      send(piobc_pkg::OP_CLEAR, 4'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      test_aimed(7, 1);
      load_wild_box(9);
      send(piobc_pkg::OP_LOAD, 4'd9, 4'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
      send(piobc_pkg::OP_LOAD, 4'd9, 4'd6, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
      send(piobc_pkg::OP_TEST, 4'd0, 4'd0, 32'd0, 32'h8000_0000, 32'h8000_0000,
           32'h8000_0000);
      drain();

      for (int ph = 0; ph < 7; ph++) begin
         write_csr(piobc_pkg::CSR_NUM_BOXES, {11'd0, nb_set[ph]});
         write_csr(piobc_pkg::CSR_MARGIN, mg_set[ph]);
         quiet = (ph == 2);
         if (ph == 3) hold_cycles = 600;
         for (int n = 0; n < PHASE_WORDS; n++) random_word();
         if (ph == 4) begin
            req_tvalid <= 1'b0;
            while (board.pending() != 0) @(posedge clock);
         end
         drain();
      end
      quiet = 0;

      if (board.errs == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/piobc_pkg.sv
rtl/piobc_cell.sv
rtl/points_in_oriented_boxes_count.sv
sim/testbench.sv
